@@ src/psh_pkg.sv @@
// Shared types, constants and helper functions for the PID position servo.
`timescale 1ns / 1ps
package psh_pkg;

    // Derivative scale: one second expressed in microseconds.
    localparam int unsigned DERIV_SCALE = 1000000;
    // Gains are given in thousandths.
    localparam int unsigned GAIN_DIV    = 1000;
    // Multiplier operand width of the shared unit (covers DERIV_SCALE).
    localparam int unsigned MUL_B_W     = 20;
    // Dividend width and quotient bits produced per cycle.
    localparam int unsigned DIV_A_W     = 64;
    localparam int unsigned DIV_RADIX_W = 2;
    localparam int unsigned DIV_CYCLES  = DIV_A_W / DIV_RADIX_W;
    // Width of the command sum before clamping.
    localparam int unsigned ACC_W       = 40;

    // Division by GAIN_DIV of a gain product (below 2^47). The dividend is
    // split at bit KDIV_SPLIT; since 2^24 = 1000*16777 + 216 the high half
    // contributes high*16777 to the quotient and high*216 to a residue that
    // stays below 2^31. The residue is divided by reciprocal multiplication
    // with a 38-bit shift, which is exact over that range.
    localparam int unsigned KDIV_SPLIT  = 24;
    localparam int unsigned KDIV_HI_MUL = 16777;
    localparam int unsigned KDIV_HI_REM = 216;
    localparam int unsigned KDIV_RECIP  = 274877907;
    localparam int unsigned KDIV_SHIFT  = 38;
    localparam int unsigned KDIV_CYCLES = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_D,
        ST_DIV_D,
        ST_INTEG,
        ST_MUL_P,
        ST_DIV_P,
        ST_MUL_R,
        ST_DIV_R,
        ST_MUL_I,
        ST_DIV_I,
        ST_CLAMP,
        ST_MUL_L,
        ST_DIV_L,
        ST_FINISH
    } psh_step_t;

    typedef enum logic [2:0] {
        REG_PROP_GAIN,
        REG_DERIV_GAIN,
        REG_INTEG_GAIN,
        REG_TICK_INTERVAL,
        REG_WINDUP_LIMIT,
        REG_SETPOINT_PERIOD,
        REG_REPORT_PERIOD,
        REG_REPORT_ENABLE
    } psh_reg_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] deriv_gain;
        logic [15:0] integ_gain;
        logic [15:0] tick_interval_us;
        logic [19:0] windup_limit;
        logic [15:0] setpoint_period;
        logic [15:0] report_period;
        logic        report_enable;
    } psh_cfg_t;

    typedef struct packed {
        psh_step_t step;
        logic      load;
        logic      start;
    } psh_cmd_t;

    typedef struct packed {
        logic arith_done;
        logic cmd_zero;
        logic out_full;
    } psh_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/pid_position_servo_hbridge.sv @@
// Top level of the PID position servo: register port, controller and datapath.
// Each accepted item is one control tick. The block latches the offered
// setpoint every setpoint_period ticks, forms the position error, a
// derivative scaled by 1e6/tick_interval_us and a saturating integrator that
// is cleared when the error magnitude exceeds windup_limit, sums the three
// gain products (each divided by 1000, truncated toward zero), clamps the sum
// to the supply voltage and returns one result item with the command and the
// forward/reverse PWM levels out of PWM_TOP. One item is processed at a time,
// and the next item can be taken while the previous result waits in the
// output register. Each item runs five multiplications on the shared
// shift-add unit, two divisions by a register value (tick interval and
// supply) on the radix-4 divider and three divisions by the gain scale by
// reciprocal multiplication, besides the error, integrator, clamp and
// finish steps. The finish step holds a new result while the previous one
// still waits on m_ready. When the clamped command is zero the level
// multiply and divide are skipped. The user must write registers through
// the APB port only while no item is in flight; the block itself does not
// enforce this.
`timescale 1ns / 1ps
module pid_position_servo_hbridge #(
    parameter int unsigned PWM_TOP = 1250
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Tick items in.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [31:0]            s_position,
    input  logic [15:0]                   s_supply_mv,
    input  logic signed [31:0]            s_new_setpoint,
    input  logic                          s_setpoint_offered,
    // Result items out.
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [16:0]            m_command_mv,
    output logic [$clog2(PWM_TOP+1)-1:0]  m_forward_level,
    output logic [$clog2(PWM_TOP+1)-1:0]  m_reverse_level,
    output logic                          m_report_valid,
    output logic signed [31:0]            m_report_target,
    output logic signed [31:0]            m_report_position
);

    // Level ports are just wide enough to hold PWM_TOP.
    localparam int unsigned LVL_W = $clog2(PWM_TOP + 1);

    psh_pkg::psh_cfg_t cfg_reg, cfg_next;
    psh_pkg::psh_cmd_t cmd;
    psh_pkg::psh_sts_t sts;
    psh_pkg::psh_reg_t reg_sel;
    logic              wr_en;

    // Registers sit on 32-bit word addresses; the low address bits are ignored.
    assign reg_sel = psh_pkg::psh_reg_t'(paddr[4:2]);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain        <= 16'd0;
            cfg_reg.deriv_gain       <= 16'd0;
            cfg_reg.integ_gain       <= 16'd0;
            cfg_reg.tick_interval_us <= 16'd1000;
            cfg_reg.windup_limit     <= 20'd1000;
            cfg_reg.setpoint_period  <= 16'd1;
            cfg_reg.report_period    <= 16'd1;
            cfg_reg.report_enable    <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                psh_pkg::REG_PROP_GAIN:       cfg_next.prop_gain        = pwdata[15:0];
                psh_pkg::REG_DERIV_GAIN:      cfg_next.deriv_gain       = pwdata[15:0];
                psh_pkg::REG_INTEG_GAIN:      cfg_next.integ_gain       = pwdata[15:0];
                psh_pkg::REG_TICK_INTERVAL:   cfg_next.tick_interval_us = pwdata[15:0];
                psh_pkg::REG_WINDUP_LIMIT:    cfg_next.windup_limit     = pwdata[19:0];
                psh_pkg::REG_SETPOINT_PERIOD: cfg_next.setpoint_period  = pwdata[15:0];
                psh_pkg::REG_REPORT_PERIOD:   cfg_next.report_period    = pwdata[15:0];
                psh_pkg::REG_REPORT_ENABLE:   cfg_next.report_enable    = pwdata[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Read back the register selected by the address.
    always_comb begin
        unique case (reg_sel)
            psh_pkg::REG_PROP_GAIN:       prdata = 32'(cfg_reg.prop_gain);
            psh_pkg::REG_DERIV_GAIN:      prdata = 32'(cfg_reg.deriv_gain);
            psh_pkg::REG_INTEG_GAIN:      prdata = 32'(cfg_reg.integ_gain);
            psh_pkg::REG_TICK_INTERVAL:   prdata = 32'(cfg_reg.tick_interval_us);
            psh_pkg::REG_WINDUP_LIMIT:    prdata = 32'(cfg_reg.windup_limit);
            psh_pkg::REG_SETPOINT_PERIOD: prdata = 32'(cfg_reg.setpoint_period);
            psh_pkg::REG_REPORT_PERIOD:   prdata = 32'(cfg_reg.report_period);
            psh_pkg::REG_REPORT_ENABLE:   prdata = 32'(cfg_reg.report_enable);
            default:                      prdata = '0;
        endcase
    end

    // The controller owns sequencing; the datapath holds all servo state.
    psh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    psh_datapath #(
        .PWM_TOP (PWM_TOP),
        .LVL_W   (LVL_W)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .cmd                (cmd),
        .sts                (sts),
        .s_position         (s_position),
        .s_supply_mv        (s_supply_mv),
        .s_new_setpoint     (s_new_setpoint),
        .s_setpoint_offered (s_setpoint_offered),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_command_mv       (m_command_mv),
        .m_forward_level    (m_forward_level),
        .m_reverse_level    (m_reverse_level),
        .m_report_valid     (m_report_valid),
        .m_report_target    (m_report_target),
        .m_report_position  (m_report_position)
    );

endmodule

@@ src/psh_arith.sv @@
// Shared iterative unit: shift-add multiplier, radix-4 divider and gain-scale divider.
`timescale 1ns / 1ps
module psh_arith (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        div_mode,
    input  logic        const_div,
    input  logic [63:0] op_a,
    input  logic [31:0] op_b,
    output logic        done,
    output logic [63:0] result
);

    localparam int unsigned CNT_W = $clog2(psh_pkg::DIV_CYCLES);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        div_reg, div_next;
    logic                        kdiv_reg, kdiv_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [63:0]                 acc_reg, acc_next;
    logic [63:0]                 mcand_reg, mcand_next;
    logic [psh_pkg::MUL_B_W-1:0] mplier_reg, mplier_next;
    logic [31:0]                 rem_reg, rem_next;
    logic [31:0]                 dvsr_reg, dvsr_next;

    logic [32:0] r1, r2;
    logic        q1, q2;
    logic [31:0] kd_y;
    logic [63:0] kd_hq;
    logic [63:0] kd_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        div_reg    <= div_next;
        kdiv_reg   <= kdiv_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        dvsr_reg   <= dvsr_next;
    end

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        div_next    = div_reg;
        kdiv_next   = kdiv_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        rem_next    = rem_reg;
        dvsr_next   = dvsr_reg;

        // Two restoring division steps per cycle.
        r1 = {rem_reg, acc_reg[63]};
        q1 = (r1 >= {1'b0, dvsr_reg});
        if (q1) begin
            r1 = r1 - {1'b0, dvsr_reg};
        end
        r2 = {r1[31:0], acc_reg[62]};
        q2 = (r2 >= {1'b0, dvsr_reg});
        if (q2) begin
            r2 = r2 - {1'b0, dvsr_reg};
        end

        // Gain-scale division terms: residue and high quotient, then the
        // residue quotient by reciprocal multiplication.
        kd_y    = 32'(acc_reg[47:psh_pkg::KDIV_SPLIT]) * 32'(psh_pkg::KDIV_HI_REM)
                + 32'(acc_reg[psh_pkg::KDIV_SPLIT-1:0]);
        kd_hq   = 64'(acc_reg[47:psh_pkg::KDIV_SPLIT]) * 64'(psh_pkg::KDIV_HI_MUL);
        kd_prod = 64'(rem_reg) * 64'(psh_pkg::KDIV_RECIP);

        if (start) begin
            busy_next = 1'b1;
            div_next  = div_mode;
            kdiv_next = div_mode && const_div;
            if (div_mode && const_div) begin
                acc_next = op_a;
                cnt_next = CNT_W'(psh_pkg::KDIV_CYCLES - 1);
            end else if (div_mode) begin
                acc_next = op_a;
                cnt_next = CNT_W'(psh_pkg::DIV_CYCLES - 1);
            end else begin
                acc_next = '0;
                cnt_next = CNT_W'(psh_pkg::MUL_B_W - 1);
            end
            mcand_next  = op_a;
            mplier_next = op_b[psh_pkg::MUL_B_W-1:0];
            rem_next    = '0;
            dvsr_next   = op_b;
        end else if (busy_reg) begin
            if (kdiv_reg) begin
                if (cnt_reg == CNT_W'(psh_pkg::KDIV_CYCLES - 1)) begin
                    rem_next   = kd_y;
                    mcand_next = kd_hq;
                end else if (cnt_reg == CNT_W'(1)) begin
                    acc_next = kd_prod >> psh_pkg::KDIV_SHIFT;
                end else begin
                    acc_next = mcand_reg + acc_reg;
                end
            end else if (div_reg) begin
                acc_next = {acc_reg[61:0], q1, q2};
                rem_next = r2[31:0];
            end else begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[62:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[psh_pkg::MUL_B_W-1:1]};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

@@ src/psh_ctrl.sv @@
// Controller state machine that sequences one control tick through the datapath.
`timescale 1ns / 1ps
module psh_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  psh_pkg::psh_sts_t sts,
    output psh_pkg::psh_cmd_t cmd
);

    psh_pkg::psh_step_t state_reg, state_next;
    logic               started_reg, started_next;
    logic               arith_step;
    logic               skip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= psh_pkg::ST_IDLE;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        started_next = started_reg;
        arith_step   = 1'b0;
        skip         = 1'b0;
        cmd.step     = state_reg;
        cmd.load     = 1'b0;
        cmd.start    = 1'b0;
        s_ready      = 1'b0;

        unique case (state_reg)
            psh_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = psh_pkg::ST_ERR;
                end
            end
            psh_pkg::ST_ERR:    state_next = psh_pkg::ST_MUL_D;
            psh_pkg::ST_MUL_D: begin
                arith_step = 1'b1;
                if (sts.arith_done) state_next = psh_pkg::ST_DIV_D;
            end
            psh_pkg::ST_DIV_D: begin
                arith_step = 1'b1;
                if (sts.arith_done) state_next = psh_pkg::ST_INTEG;
            end
            psh_pkg::ST_INTEG:  state_next = psh_pkg::ST_MUL_P;
            psh_pkg::ST_MUL_P: begin
                arith_step = 1'b1;
                if (sts.arith_done) state_next = psh_pkg::ST_DIV_P;
            end
            psh_pkg::ST_DIV_P: begin
                arith_step = 1'b1;
                if (sts.arith_done) state_next = psh_pkg::ST_MUL_R;
            end
            psh_pkg::ST_MUL_R: begin
                arith_step = 1'b1;
                if (sts.arith_done) state_next = psh_pkg::ST_DIV_R;
            end
            psh_pkg::ST_DIV_R: begin
                arith_step = 1'b1;
                if (sts.arith_done) state_next = psh_pkg::ST_MUL_I;
            end
            psh_pkg::ST_MUL_I: begin
                arith_step = 1'b1;
                if (sts.arith_done) state_next = psh_pkg::ST_DIV_I;
            end
            psh_pkg::ST_DIV_I: begin
                arith_step = 1'b1;
                if (sts.arith_done) state_next = psh_pkg::ST_CLAMP;
            end
            psh_pkg::ST_CLAMP:  state_next = psh_pkg::ST_MUL_L;
            psh_pkg::ST_MUL_L: begin
                // A zero command needs no level computation.
                if (sts.cmd_zero) begin
                    skip       = 1'b1;
                    state_next = psh_pkg::ST_FINISH;
                end else begin
                    arith_step = 1'b1;
                    if (sts.arith_done) state_next = psh_pkg::ST_DIV_L;
                end
            end
            psh_pkg::ST_DIV_L: begin
                arith_step = 1'b1;
                if (sts.arith_done) state_next = psh_pkg::ST_FINISH;
            end
            psh_pkg::ST_FINISH: begin
                if (!sts.out_full) state_next = psh_pkg::ST_IDLE;
            end
            default:            state_next = psh_pkg::ST_IDLE;
        endcase

        if (arith_step && !skip) begin
            if (!started_reg) begin
                cmd.start    = 1'b1;
                started_next = 1'b1;
            end else if (sts.arith_done) begin
                started_next = 1'b0;
            end
        end
    end

endmodule

@@ src/psh_datapath.sv @@
// Datapath: servo state, operand selection, shared arithmetic unit and result register.
`timescale 1ns / 1ps
module psh_datapath #(
    parameter int unsigned PWM_TOP = 1250,
    parameter int unsigned LVL_W   = 11
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  psh_pkg::psh_cfg_t        cfg,
    input  psh_pkg::psh_cmd_t        cmd,
    output psh_pkg::psh_sts_t        sts,
    input  logic signed [31:0]       s_position,
    input  logic [15:0]              s_supply_mv,
    input  logic signed [31:0]       s_new_setpoint,
    input  logic                     s_setpoint_offered,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [16:0]       m_command_mv,
    output logic [LVL_W-1:0]         m_forward_level,
    output logic [LVL_W-1:0]         m_reverse_level,
    output logic                     m_report_valid,
    output logic signed [31:0]       m_report_target,
    output logic signed [31:0]       m_report_position
);

    localparam int unsigned ACC_W = psh_pkg::ACC_W;

    // Servo state.
    logic signed [31:0]      target_reg, target_next;
    logic signed [31:0]      last_err_reg, last_err_next;
    logic signed [31:0]      sum_reg, sum_next;
    logic [15:0]             sp_cnt_reg, sp_cnt_next;
    logic [15:0]             rp_cnt_reg, rp_cnt_next;
    // Per-tick working registers.
    logic signed [31:0]      pos_reg, pos_next;
    logic [15:0]             sup_reg, sup_next;
    logic                    rep_reg, rep_next;
    logic signed [31:0]      rep_tgt_reg, rep_tgt_next;
    logic signed [31:0]      err_reg, err_next;
    logic signed [31:0]      rate_reg, rate_next;
    logic                    neg_reg, neg_next;
    logic [63:0]             prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [16:0]      cmd_reg, cmd_next;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    // Result register.
    logic                    ov_reg, ov_next;
    logic signed [16:0]      o_cmd_reg, o_cmd_next;
    logic [LVL_W-1:0]        o_fwd_reg, o_fwd_next;
    logic [LVL_W-1:0]        o_rev_reg, o_rev_next;
    logic                    o_rep_reg, o_rep_next;
    logic signed [31:0]      o_tgt_reg, o_tgt_next;
    logic signed [31:0]      o_pos_reg, o_pos_next;

    // Shared arithmetic unit.
    logic        ar_div, ar_kdiv, ar_done;
    logic [63:0] ar_a, ar_res;
    logic [31:0] ar_b;
    logic        ar_neg;

    logic signed [32:0]      delta;
    logic [32:0]             err_mag;
    logic signed [63:0]      q_signed;
    logic signed [ACC_W-1:0] sup_s;
    logic [16:0]             cmd_mag;
    logic                    out_full;

    psh_arith u_arith (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.start),
        .div_mode  (ar_div),
        .const_div (ar_kdiv),
        .op_a      (ar_a),
        .op_b      (ar_b),
        .done      (ar_done),
        .result    (ar_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= '0;
            last_err_reg <= '0;
            sum_reg      <= '0;
            sp_cnt_reg   <= 16'd1;
            rp_cnt_reg   <= 16'd1;
            ov_reg       <= 1'b0;
        end else begin
            target_reg   <= target_next;
            last_err_reg <= last_err_next;
            sum_reg      <= sum_next;
            sp_cnt_reg   <= sp_cnt_next;
            rp_cnt_reg   <= rp_cnt_next;
            ov_reg       <= ov_next;
        end
        pos_reg     <= pos_next;
        sup_reg     <= sup_next;
        rep_reg     <= rep_next;
        rep_tgt_reg <= rep_tgt_next;
        err_reg     <= err_next;
        rate_reg    <= rate_next;
        neg_reg     <= neg_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        cmd_reg     <= cmd_next;
        lvl_reg     <= lvl_next;
        o_cmd_reg   <= o_cmd_next;
        o_fwd_reg   <= o_fwd_next;
        o_rev_reg   <= o_rev_next;
        o_rep_reg   <= o_rep_next;
        o_tgt_reg   <= o_tgt_next;
        o_pos_reg   <= o_pos_next;
    end

    assign delta    = 33'(err_reg) - 33'(last_err_reg);
    assign err_mag  = err_reg[31] ? 33'(-33'(err_reg)) : 33'(err_reg);
    assign q_signed = neg_reg ? -$signed(ar_res) : $signed(ar_res);
    assign sup_s    = $signed(ACC_W'(sup_reg));
    assign cmd_mag  = cmd_reg[16] ? 17'(-cmd_reg) : 17'(cmd_reg);
    assign out_full = ov_reg && !m_ready;

    // Operand selection for the shared unit.
    always_comb begin
        ar_div  = 1'b0;
        ar_kdiv = 1'b0;
        ar_a    = '0;
        ar_b    = '0;
        ar_neg  = 1'b0;
        unique case (cmd.step)
            psh_pkg::ST_MUL_D: begin
                ar_neg = delta[32];
                ar_a   = 64'(delta[32] ? 33'(-delta) : 33'(delta));
                ar_b   = 32'(psh_pkg::DERIV_SCALE);
            end
            psh_pkg::ST_DIV_D: begin
                ar_div = 1'b1;
                ar_a   = prod_reg;
                ar_b   = (cfg.tick_interval_us == '0) ? 32'd1 : 32'(cfg.tick_interval_us);
            end
            psh_pkg::ST_MUL_P: begin
                ar_neg = err_reg[31];
                ar_a   = 64'(err_mag);
                ar_b   = 32'(cfg.prop_gain);
            end
            psh_pkg::ST_MUL_R: begin
                ar_neg = rate_reg[31];
                ar_a   = 64'(rate_reg[31] ? 33'(-33'(rate_reg)) : 33'(rate_reg));
                ar_b   = 32'(cfg.deriv_gain);
            end
            psh_pkg::ST_MUL_I: begin
                ar_neg = sum_reg[31];
                ar_a   = 64'(sum_reg[31] ? 33'(-33'(sum_reg)) : 33'(sum_reg));
                ar_b   = 32'(cfg.integ_gain);
            end
            psh_pkg::ST_DIV_P, psh_pkg::ST_DIV_R, psh_pkg::ST_DIV_I: begin
                ar_div  = 1'b1;
                ar_kdiv = 1'b1;
                ar_a    = prod_reg;
                ar_b    = 32'(psh_pkg::GAIN_DIV);
            end
            psh_pkg::ST_MUL_L: begin
                ar_a = 64'(cmd_mag);
                ar_b = 32'(PWM_TOP);
            end
            psh_pkg::ST_DIV_L: begin
                ar_div = 1'b1;
                ar_a   = prod_reg;
                ar_b   = 32'(sup_reg);
            end
            default: begin
                ar_div = 1'b0;
            end
        endcase
    end

    always_comb begin
        target_next   = target_reg;
        last_err_next = last_err_reg;
        sum_next      = sum_reg;
        sp_cnt_next   = sp_cnt_reg;
        rp_cnt_next   = rp_cnt_reg;
        pos_next      = pos_reg;
        sup_next      = sup_reg;
        rep_next      = rep_reg;
        rep_tgt_next  = rep_tgt_reg;
        err_next      = err_reg;
        rate_next     = rate_reg;
        neg_next      = neg_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        cmd_next      = cmd_reg;
        lvl_next      = lvl_reg;
        ov_next       = ov_reg && !m_ready;
        o_cmd_next    = o_cmd_reg;
        o_fwd_next    = o_fwd_reg;
        o_rev_next    = o_rev_reg;
        o_rep_next    = o_rep_reg;
        o_tgt_next    = o_tgt_reg;
        o_pos_next    = o_pos_reg;

        if (cmd.start && !ar_div) begin
            neg_next = ar_neg;
        end

        // Setpoint latch and report tick are settled when the item is taken.
        if (cmd.load) begin
            pos_next     = s_position;
            sup_next     = s_supply_mv;
            rep_tgt_next = target_reg;
            if (sp_cnt_reg == cfg.setpoint_period) begin
                if (s_setpoint_offered) begin
                    target_next  = s_new_setpoint;
                    rep_tgt_next = s_new_setpoint;
                end
                sp_cnt_next = 16'd1;
            end else begin
                sp_cnt_next = sp_cnt_reg + 16'd1;
            end
            if ((rp_cnt_reg == cfg.report_period) && cfg.report_enable) begin
                rep_next    = 1'b1;
                rp_cnt_next = 16'd1;
            end else begin
                rep_next    = 1'b0;
                rp_cnt_next = rp_cnt_reg + 16'd1;
            end
        end

        unique case (cmd.step)
            psh_pkg::ST_ERR: begin
                err_next = psh_pkg::sat32(64'(target_reg) - 64'(pos_reg));
            end
            psh_pkg::ST_MUL_D, psh_pkg::ST_MUL_P, psh_pkg::ST_MUL_R,
            psh_pkg::ST_MUL_I, psh_pkg::ST_MUL_L: begin
                if (ar_done) prod_next = ar_res;
            end
            psh_pkg::ST_DIV_D: begin
                if (ar_done) rate_next = psh_pkg::sat32(q_signed);
            end
            psh_pkg::ST_INTEG: begin
                last_err_next = err_reg;
                acc_next      = '0;
                if (err_mag > 33'(cfg.windup_limit)) begin
                    sum_next = '0;
                end else begin
                    sum_next = psh_pkg::sat32(64'(sum_reg) + 64'(err_reg));
                end
            end
            psh_pkg::ST_DIV_P, psh_pkg::ST_DIV_R, psh_pkg::ST_DIV_I: begin
                if (ar_done) acc_next = acc_reg + ACC_W'(q_signed);
            end
            psh_pkg::ST_CLAMP: begin
                lvl_next = '0;
                if (acc_reg > sup_s) begin
                    cmd_next = 17'(sup_s);
                end else if (acc_reg < -sup_s) begin
                    cmd_next = 17'(-sup_s);
                end else begin
                    cmd_next = 17'(acc_reg);
                end
            end
            psh_pkg::ST_DIV_L: begin
                if (ar_done) lvl_next = LVL_W'(ar_res);
            end
            psh_pkg::ST_FINISH: begin
                if (!out_full) begin
                    ov_next    = 1'b1;
                    o_cmd_next = cmd_reg;
                    o_fwd_next = (!cmd_reg[16] && cmd_reg != '0) ? lvl_reg : '0;
                    o_rev_next = cmd_reg[16] ? lvl_reg : '0;
                    o_rep_next = rep_reg;
                    o_tgt_next = rep_reg ? rep_tgt_reg : '0;
                    o_pos_next = rep_reg ? pos_reg : '0;
                end
            end
            default: begin
                ov_next = ov_reg && !m_ready;
            end
        endcase
    end

    assign sts.arith_done = ar_done;
    assign sts.cmd_zero   = (cmd_reg == '0);
    assign sts.out_full   = out_full;

    assign m_valid           = ov_reg;
    assign m_command_mv      = o_cmd_reg;
    assign m_forward_level   = o_fwd_reg;
    assign m_reverse_level   = o_rev_reg;
    assign m_report_valid    = o_rep_reg;
    assign m_report_target   = o_tgt_reg;
    assign m_report_position = o_pos_reg;

endmodule

@@ src/psh_checker.sv @@
// Port-level checker for the servo result channel, bound to the top level.
`timescale 1ns / 1ps
module psh_checker #(
    parameter int unsigned LVL_W = 11
) (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic signed [16:0]       m_command_mv,
    input logic [LVL_W-1:0]         m_forward_level,
    input logic [LVL_W-1:0]         m_reverse_level,
    input logic                     m_report_valid,
    input logic signed [31:0]       m_report_target,
    input logic signed [31:0]       m_report_position
);

    // A stalled result item holds its command.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command_mv))
        else $error("result item changed while stalled");

    // Only one bridge direction is driven at a time.
    a_one_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_forward_level == '0) || (m_reverse_level == '0))
        else $error("both bridge directions active");

    // The forward level is zero unless the command is positive.
    a_dir_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_command_mv > 0) |-> m_forward_level == '0)
        else $error("forward level without positive command");

    // Telemetry fields are zero when no report is flagged.
    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_report_valid |-> (m_report_target == 0) && (m_report_position == 0))
        else $error("telemetry fields nonzero without report");

endmodule

bind pid_position_servo_hbridge psh_checker #(.LVL_W(LVL_W)) u_psh_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_command_mv      (m_command_mv),
    .m_forward_level   (m_forward_level),
    .m_reverse_level   (m_reverse_level),
    .m_report_valid    (m_report_valid),
    .m_report_target   (m_report_target),
    .m_report_position (m_report_position)
);

@@ dv/tb_pid_position_servo_hbridge.sv @@
// Self-checking testbench for the PID position servo with H-bridge outputs.
`timescale 1ns / 1ps
module tb_pid_position_servo_hbridge;

    localparam int unsigned PWM_LEVEL_TOP = 1250;
    localparam int LVL_W = $clog2(PWM_LEVEL_TOP + 1);

    // One control tick as offered to the block.
    typedef struct {
        logic signed [31:0] position;
        logic [15:0]        supply_mv;
        logic signed [31:0] new_setpoint;
        logic               setpoint_offered;
    } tick_t;

    // One result item as the block should present it.
    typedef struct {
        logic signed [16:0] command_mv;
        logic [LVL_W-1:0]   forward_level;
        logic [LVL_W-1:0]   reverse_level;
        logic               report_valid;
        logic signed [31:0] report_target;
        logic signed [31:0] report_position;
    } servo_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_position = '0;
    logic [15:0] s_supply_mv = '0;
    logic signed [31:0] s_new_setpoint = '0;
    logic s_setpoint_offered = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [16:0] m_command_mv;
    logic [LVL_W-1:0] m_forward_level, m_reverse_level;
    logic m_report_valid;
    logic signed [31:0] m_report_target, m_report_position;

    pid_position_servo_hbridge #(.PWM_TOP(PWM_LEVEL_TOP)) dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Shadow copy of the registers and the controller state.
    psh_pkg::psh_cfg_t cfg;
    logic signed [31:0] sp_target, prev_error, integ_sum;
    logic [15:0] sp_count, rpt_count;

    tick_t pending_ticks[$];
    servo_out_t expected_results[$];
    int n_errors = 0;
    int n_results = 0;
    int n_reports = 0;
    int n_ticks_sent = 0;
    bit quiet_phase = 1'b0;   // no idling on either side while set
    logic signed [31:0] sp_guess = 0;

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Computes the result of one tick and advances the shadow state.
    function automatic servo_out_t servo_tick(input tick_t t);
        servo_out_t r;
        logic signed [31:0] err;
        logic signed [63:0] rate, cmd, sup, dv, lim;
        if (sp_count == cfg.setpoint_period) begin
            if (t.setpoint_offered) sp_target = t.new_setpoint;
            sp_count = 16'd0;
        end
        sp_count = sp_count + 16'd1;
        err = clip32(64'(sp_target) - 64'(t.position));
        dv = (cfg.tick_interval_us == 0) ? 64'sd1 : $signed(64'(cfg.tick_interval_us));
        rate = clip32((64'sd1000000 * (64'(err) - 64'(prev_error))) / dv);
        integ_sum = clip32(64'(integ_sum) + 64'(err));
        prev_error = err;
        lim = $signed(64'(cfg.windup_limit));
        if (64'(err) > lim || 64'(err) < -lim)
            integ_sum = '0;
        cmd = ($signed(64'(cfg.prop_gain)) * 64'(err)) / 1000
            + ($signed(64'(cfg.deriv_gain)) * rate) / 1000
            + ($signed(64'(cfg.integ_gain)) * 64'(integ_sum)) / 1000;
        sup = 64'(t.supply_mv);
        if (cmd > sup) cmd = sup;
        if (cmd < -sup) cmd = -sup;
        r.command_mv = cmd[16:0];
        r.forward_level = '0;
        r.reverse_level = '0;
        if (cmd > 0) r.forward_level = LVL_W'((64'sd1250 * cmd) / sup);
        else if (cmd < 0) r.reverse_level = LVL_W'((64'sd1250 * -cmd) / sup);
        r.report_valid = (rpt_count == cfg.report_period) && cfg.report_enable;
        if (r.report_valid) rpt_count = 16'd0;
        rpt_count = rpt_count + 16'd1;
        r.report_target = r.report_valid ? sp_target : '0;
        r.report_position = r.report_valid ? t.position : '0;
        return r;
    endfunction

    // Driver: presents queued ticks, holding each one until it is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready) begin
                if (pending_ticks.size() > 0 &&
                    (quiet_phase || $urandom_range(99) >= 24)) begin
                    s_valid <= 1'b1;
                    s_position <= pending_ticks[0].position;
                    s_supply_mv <= pending_ticks[0].supply_mv;
                    s_new_setpoint <= pending_ticks[0].new_setpoint;
                    s_setpoint_offered <= pending_ticks[0].setpoint_offered;
                    void'(pending_ticks.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= quiet_phase || ($urandom_range(99) >= 24);
        end
    end

    // Monitor: predicts on each accepted tick, checks each accepted result.
    always @(posedge aclk) begin
        servo_out_t e;
        tick_t t;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                t.position = s_position;
                t.supply_mv = s_supply_mv;
                t.new_setpoint = s_new_setpoint;
                t.setpoint_offered = s_setpoint_offered;
                expected_results.push_back(servo_tick(t));
                n_ticks_sent++;
            end
            if (m_valid && m_ready) begin
                n_results++;
                if (m_report_valid) n_reports++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, command %0d", $time, m_command_mv);
                    n_errors++;
                end else begin
                    e = expected_results.pop_front();
                    if (m_command_mv !== e.command_mv || m_forward_level !== e.forward_level ||
                        m_reverse_level !== e.reverse_level ||
                        m_report_valid !== e.report_valid ||
                        m_report_target !== e.report_target ||
                        m_report_position !== e.report_position) begin
                        $display("%0t: expected cmd %0d fwd %0d rev %0d rpt %0b tgt %0d pos %0d",
                                 $time, e.command_mv, e.forward_level, e.reverse_level,
                                 e.report_valid, e.report_target, e.report_position);
                        $display("%0t: actual   cmd %0d fwd %0d rev %0d rpt %0b tgt %0d pos %0d",
                                 $time, m_command_mv, m_forward_level, m_reverse_level,
                                 m_report_valid, m_report_target, m_report_position);
                        n_errors++;
                    end
                end
            end
        end
    end

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic reg_write(input psh_pkg::psh_reg_t idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            psh_pkg::REG_PROP_GAIN:       cfg.prop_gain = val[15:0];
            psh_pkg::REG_DERIV_GAIN:      cfg.deriv_gain = val[15:0];
            psh_pkg::REG_INTEG_GAIN:      cfg.integ_gain = val[15:0];
            psh_pkg::REG_TICK_INTERVAL:   cfg.tick_interval_us = val[15:0];
            psh_pkg::REG_WINDUP_LIMIT:    cfg.windup_limit = val[19:0];
            psh_pkg::REG_SETPOINT_PERIOD: cfg.setpoint_period = val[15:0];
            psh_pkg::REG_REPORT_PERIOD:   cfg.report_period = val[15:0];
            default:                      cfg.report_enable = val[0];
        endcase
    endtask

    // Waits until every queued tick is taken and every result has come back.
    task automatic drain();
        while (pending_ticks.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic add_tick(input logic signed [31:0] pos, input logic [15:0] sup,
                            input logic signed [31:0] sp, input logic off);
        tick_t t;
        t.position = pos;
        t.supply_mv = sup;
        t.new_setpoint = sp;
        t.setpoint_offered = off;
        pending_ticks.push_back(t);
    endtask

    // A random tick: mostly positions near the target so that the integrator
    // and levels stay interesting, with occasional full-range values.
    task automatic add_random_tick();
        logic signed [31:0] pos, sp;
        logic [15:0] sup;
        sp = ($urandom_range(9) == 0) ? $urandom : $signed($urandom_range(4000)) - 2000;
        pos = ($urandom_range(9) == 0) ? $urandom
            : sp_guess + $signed($urandom_range(3000)) - 1500;
        case ($urandom_range(9))
            0:       sup = 16'd0;
            1:       sup = 16'hFFFF;
            2:       sup = 16'd60000;
            default: sup = $urandom_range(60000);
        endcase
        add_tick(pos, sup, sp, $urandom_range(1));
        sp_guess = sp;
    endtask

    // Programs one random setting; gains kept moderate most of the time.
    task automatic random_setting();
        reg_write(psh_pkg::REG_PROP_GAIN,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(5000));
        reg_write(psh_pkg::REG_DERIV_GAIN,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(50));
        reg_write(psh_pkg::REG_INTEG_GAIN,
                  $urandom_range(3) == 0 ? $urandom : $urandom_range(500));
        reg_write(psh_pkg::REG_TICK_INTERVAL,
                  $urandom_range(4) == 0 ? $urandom : $urandom_range(1, 5000));
        reg_write(psh_pkg::REG_WINDUP_LIMIT,
                  $urandom_range(4) == 0 ? $urandom : $urandom_range(3000));
        reg_write(psh_pkg::REG_SETPOINT_PERIOD, $urandom_range(1, 6));
        reg_write(psh_pkg::REG_REPORT_PERIOD, $urandom_range(1, 6));
        reg_write(psh_pkg::REG_REPORT_ENABLE, $urandom_range(1));
    endtask

    initial begin
        cfg = '0;
        cfg.tick_interval_us = 16'd1000;
        cfg.windup_limit = 20'd1000;
        cfg.setpoint_period = 16'd1;
        cfg.report_period = 16'd1;
        sp_target = '0;
        prev_error = '0;
        integ_sum = '0;
        sp_count = 16'd1;
        rpt_count = 16'd1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset configuration gives a zero command everywhere.
        add_tick(32'sh7FFF_FFFF, 16'd60000, 32'sh8000_0000, 1'b1);
        drain();
        reg_write(psh_pkg::REG_PROP_GAIN, 32'd1000);
        reg_write(psh_pkg::REG_DERIV_GAIN, 32'd0);
        reg_write(psh_pkg::REG_INTEG_GAIN, 32'd65535);
        reg_write(psh_pkg::REG_TICK_INTERVAL, 32'd0);     // zero interval acts as one
        reg_write(psh_pkg::REG_WINDUP_LIMIT, 32'd1000000);
        reg_write(psh_pkg::REG_SETPOINT_PERIOD, 32'd2);
        reg_write(psh_pkg::REG_REPORT_PERIOD, 32'd1);
        reg_write(psh_pkg::REG_REPORT_ENABLE, 32'd1);
        // Error saturation both ways, zero supply, odd supply, setpoint latch.
        add_tick(32'sh8000_0000, 16'd60000, 32'sh7FFF_FFFF, 1'b1);
        add_tick(32'sh7FFF_FFFF, 16'd60000, 32'sh8000_0000, 1'b1);
        add_tick(32'sh7FFF_FFFF, 16'd0, 32'sh0, 1'b0);
        add_tick(32'sd100, 16'd12345, 32'sd0, 1'b1);
        add_tick(-32'sd100, 16'hFFFF, 32'sd5, 1'b0);
        add_tick(32'sd0, 16'd1, 32'sd0, 1'b1);
        add_tick(32'sd0, 16'd1000, 32'sd0, 1'b0);
        drain();
        reg_write(psh_pkg::REG_DERIV_GAIN, 32'd65535);
        reg_write(psh_pkg::REG_TICK_INTERVAL, 32'd65535);
        reg_write(psh_pkg::REG_WINDUP_LIMIT, 32'd0);
        reg_write(psh_pkg::REG_PROP_GAIN, 32'd65535);
        reg_write(psh_pkg::REG_SETPOINT_PERIOD, 32'd0);   // wraps: one latch per 65536
        reg_write(psh_pkg::REG_REPORT_PERIOD, 32'd65535);
        add_tick(32'sd3, 16'd60000, 32'sd7, 1'b1);
        add_tick(-32'sd3, 16'd60000, 32'sd9, 1'b1);
        add_tick(32'sd1, 16'd500, -32'sd1, 1'b1);
        add_tick(32'sh5555_5555, 16'hAAAA, 32'shAAAA_AAAA, 1'b0);
        add_tick(32'shAAAA_AAAA, 16'h5555, 32'sh5555_5555, 1'b1);
        drain();

        // Random phases, each with its own setting; one phase without idling.
        for (int ph = 0; ph < 12; ph++) begin
            random_setting();
            quiet_phase = (ph == 5);
            for (int k = 0; k < 150; k++) add_random_tick();
            drain();
        end
        quiet_phase = 1'b0;

        if (n_errors == 0) begin
            $display("Covered %0d ticks and %0d results (%0d telemetry reports).",
                     n_ticks_sent, n_results, n_reports);
            $display("end of test: clean");
        end else begin
            $display("Covered %0d ticks, %0d mismatching results.", n_ticks_sent, n_errors);
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: a time limit well beyond what about 2000 ticks need.
    initial begin
        #40ms;
        $display("Timeout with %0d results still due.", expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
